/* src/boxov_pkg.sv */
// shared constants, widths and a helper for the box overlap test block
package boxov_pkg;

    // fixed-point configuration
    localparam int ROT_FRAC_BITS = 14;
    localparam int POS_WIDTH     = 32;

    // field widths of one input word
    localparam int AXIS_W = 2;
    localparam int CTR_W  = 31;
    localparam int ROW_W  = 16;
    localparam int HE_W   = 29;

    // field widths of one result word
    localparam int DEPTH_W = 32;

    // packed stream widths
    localparam int S_FIELDS_W = CTR_W + 3 * ROW_W + 3 * HE_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_USER_W   = AXIS_W + 1;
    localparam int M_FIELDS_W = 1 + AXIS_W + DEPTH_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // datapath widths
    localparam int MAG_W  = ROW_W;
    localparam int PROD_W = MAG_W + HE_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RAD_W  = SUM_W - ROT_FRAC_BITS;
    localparam int END_W  = POS_WIDTH + 1;
    localparam int CW_A   = (CTR_W > RAD_W + 1) ? CTR_W : RAD_W + 1;
    localparam int CW_B   = (CW_A > END_W) ? CW_A : END_W;
    localparam int CW     = CW_B + 1;
    localparam int DW     = (END_W + 1 > DEPTH_W + 2) ? END_W + 1 : DEPTH_W + 2;

    // world axis codes
    localparam logic [AXIS_W-1:0] AXIS_X       = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y       = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z       = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_INVALID = 2'd3;

    // magnitude of a signed rotation element, most negative code maps to 2^15
    function automatic logic [MAG_W-1:0] row_mag(input logic [ROW_W-1:0] v);
        row_mag = v[ROW_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

/* src/box_axis_overlap_mtv.sv */
// box overlap test on world axes with minimum translation vector
//
// Input words arrive on the s_axis channel, six per box pair: axis x, y, z in
// turn, the first box's word before the second box's word on each axis. Each
// word carries the box centre on that axis, the rotation row and the three
// half extents. After the second box's word on axis z one result word leaves
// on the m_axis channel with collides, push_axis and push_depth; axis and
// depth are zero when the boxes are apart. Words with axis code 3 are dropped.
// The input handshake edge loads the input register, and m_axis_tvalid rises
// when the result register is loaded from it through the projection
// multipliers, interval compare and best-overlap select. One word is taken
// every cycle while the input side is not held; the output register parts
// the two sides, so a stalled receiver only holds the input side when the
// word waiting in the input register would produce a result. Synchronous
// active-low reset empties both registers and clears the running best
// overlap and the stored interval.
module box_axis_overlap_mtv (
    input  logic                          aclk,
    input  logic                          aresetn,
    // fields: center_coord, row_elem_x, row_elem_y, row_elem_z,
    //         half_ext_x, half_ext_y, half_ext_z, zero pad
    input  logic [boxov_pkg::S_DATA_W-1:0] s_axis_tdata,
    // fields: axis_index, second_box
    input  logic [boxov_pkg::S_USER_W-1:0] s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // fields: collides, push_axis, push_depth, zero pad
    output logic [boxov_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    localparam int AXIS_W  = boxov_pkg::AXIS_W;
    localparam int CTR_W   = boxov_pkg::CTR_W;
    localparam int ROW_W   = boxov_pkg::ROW_W;
    localparam int HE_W    = boxov_pkg::HE_W;
    localparam int MAG_W   = boxov_pkg::MAG_W;
    localparam int PROD_W  = boxov_pkg::PROD_W;
    localparam int SUM_W   = boxov_pkg::SUM_W;
    localparam int RAD_W   = boxov_pkg::RAD_W;
    localparam int END_W   = boxov_pkg::END_W;
    localparam int CW      = boxov_pkg::CW;
    localparam int DW      = boxov_pkg::DW;
    localparam int DEPTH_W = boxov_pkg::DEPTH_W;
    localparam int POS_W   = boxov_pkg::POS_WIDTH;
    localparam int M_PAD_W = boxov_pkg::M_DATA_W - boxov_pkg::M_FIELDS_W;

    // saturation limits
    localparam logic signed [CW-1:0] END_MAX_W = {{(CW - POS_W){1'b0}}, {POS_W{1'b1}}};
    localparam logic signed [CW-1:0] END_MIN_W = ~END_MAX_W;
    localparam logic signed [END_W-1:0] END_MAX = {1'b0, {POS_W{1'b1}}};
    localparam logic signed [END_W-1:0] END_MIN = ~END_MAX;
    localparam logic signed [DW-1:0] DEPTH_MAX_W = {{(DW - DEPTH_W){1'b0}}, {DEPTH_W{1'b1}}};

    // input register
    logic                     in_valid_reg, in_valid_next;
    logic [AXIS_W-1:0]        in_axis_reg;
    logic                     in_second_reg;
    logic [CTR_W-1:0]         in_center_reg;
    logic [ROW_W-1:0]         in_rx_reg, in_ry_reg, in_rz_reg;
    logic [HE_W-1:0]          in_hx_reg, in_hy_reg, in_hz_reg;

    // running state
    logic signed [END_W-1:0]  first_low_reg, first_low_next;
    logic signed [END_W-1:0]  first_high_reg, first_high_next;
    logic [DEPTH_W-1:0]       best_depth_reg, best_depth_next;
    logic [AXIS_W-1:0]        best_axis_reg, best_axis_next;
    logic                     apart_seen_reg, apart_seen_next;

    // result register
    logic                     m_valid_reg, m_valid_next;
    logic                     m_collides_reg, m_collides_next;
    logic [AXIS_W-1:0]        m_axis_reg, m_axis_next;
    logic [DEPTH_W-1:0]       m_depth_reg, m_depth_next;

    // datapath
    logic [MAG_W-1:0]         mag_x, mag_y, mag_z;
    logic [PROD_W-1:0]        prod_x, prod_y, prod_z;
    logic [SUM_W-1:0]         proj_sum;
    logic [RAD_W-1:0]         radius;
    logic signed [CW-1:0]     centre_w, radius_w, lo_raw, hi_raw;
    logic signed [END_W-1:0]  lo, hi, ov_hi, ov_lo;
    logic signed [DW-1:0]     ov;
    logic                     ov_pos;
    logic [DEPTH_W-1:0]       depth;
    logic                     item_ok, emits, stall, go, s_accept;
    logic                     apart_now;
    logic [DEPTH_W-1:0]       best_depth_now;
    logic [AXIS_W-1:0]        best_axis_now;

    // handshake
    assign item_ok       = in_axis_reg != boxov_pkg::AXIS_INVALID;
    assign emits         = item_ok && in_second_reg && (in_axis_reg == boxov_pkg::AXIS_Z);
    assign stall         = in_valid_reg && emits && m_valid_reg && !m_axis_tready;
    assign go            = in_valid_reg && !stall && item_ok;
    assign s_axis_tready = !in_valid_reg || !stall;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // projected radius
    assign mag_x    = boxov_pkg::row_mag(in_rx_reg);
    assign mag_y    = boxov_pkg::row_mag(in_ry_reg);
    assign mag_z    = boxov_pkg::row_mag(in_rz_reg);
    assign prod_x   = PROD_W'(mag_x) * PROD_W'(in_hx_reg);
    assign prod_y   = PROD_W'(mag_y) * PROD_W'(in_hy_reg);
    assign prod_z   = PROD_W'(mag_z) * PROD_W'(in_hz_reg);
    assign proj_sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z);
    assign radius   = proj_sum[SUM_W-1:boxov_pkg::ROT_FRAC_BITS];

    // box interval with saturated ends
    assign centre_w = CW'(signed'(in_center_reg));
    assign radius_w = signed'(CW'(radius));
    assign lo_raw   = centre_w - radius_w;
    assign hi_raw   = centre_w + radius_w;

    always_comb begin
        if (lo_raw > END_MAX_W) begin
            lo = END_MAX;
        end else if (lo_raw < END_MIN_W) begin
            lo = END_MIN;
        end else begin
            lo = lo_raw[END_W-1:0];
        end
        if (hi_raw > END_MAX_W) begin
            hi = END_MAX;
        end else if (hi_raw < END_MIN_W) begin
            hi = END_MIN;
        end else begin
            hi = hi_raw[END_W-1:0];
        end
    end

    // overlap against the stored first-box interval
    assign ov_hi  = (hi < first_high_reg) ? hi : first_high_reg;
    assign ov_lo  = (lo > first_low_reg) ? lo : first_low_reg;
    assign ov     = DW'(ov_hi) - DW'(ov_lo);
    assign ov_pos = !ov[DW-1] && (ov != '0);
    assign depth  = (ov > DEPTH_MAX_W) ? {DEPTH_W{1'b1}} : ov[DEPTH_W-1:0];

    // best overlap including this word
    always_comb begin
        apart_now      = apart_seen_reg;
        best_depth_now = best_depth_reg;
        best_axis_now  = best_axis_reg;
        if (!ov_pos) begin
            apart_now = 1'b1;
        end else if (depth < best_depth_reg) begin
            best_depth_now = depth;
            best_axis_now  = in_axis_reg;
        end
    end

    // next state
    always_comb begin
        in_valid_next    = in_valid_reg;
        first_low_next   = first_low_reg;
        first_high_next  = first_high_reg;
        best_depth_next  = best_depth_reg;
        best_axis_next   = best_axis_reg;
        apart_seen_next  = apart_seen_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_collides_next  = m_collides_reg;
        m_axis_next      = m_axis_reg;
        m_depth_next     = m_depth_reg;

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (in_valid_reg && !stall) begin
            in_valid_next = 1'b0;
        end

        if (go) begin
            if (!in_second_reg) begin
                first_low_next  = lo;
                first_high_next = hi;
            end else if (emits) begin
                m_valid_next    = 1'b1;
                m_collides_next = !apart_now;
                m_axis_next     = apart_now ? boxov_pkg::AXIS_X : best_axis_now;
                m_depth_next    = apart_now ? '0 : best_depth_now;
                best_depth_next = {DEPTH_W{1'b1}};
                best_axis_next  = boxov_pkg::AXIS_X;
                apart_seen_next = 1'b0;
            end else begin
                best_depth_next = best_depth_now;
                best_axis_next  = best_axis_now;
                apart_seen_next = apart_now;
            end
        end
    end

    // control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            first_low_reg  <= '0;
            first_high_reg <= '0;
            best_depth_reg <= {DEPTH_W{1'b1}};
            best_axis_reg  <= boxov_pkg::AXIS_X;
            apart_seen_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            m_valid_reg    <= m_valid_next;
            first_low_reg  <= first_low_next;
            first_high_reg <= first_high_next;
            best_depth_reg <= best_depth_next;
            best_axis_reg  <= best_axis_next;
            apart_seen_reg <= apart_seen_next;
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_axis_reg   <= s_axis_tuser[AXIS_W-1:0];
            in_second_reg <= s_axis_tuser[AXIS_W];
            in_center_reg <= s_axis_tdata[CTR_W-1:0];
            in_rx_reg     <= s_axis_tdata[CTR_W +: ROW_W];
            in_ry_reg     <= s_axis_tdata[CTR_W + ROW_W +: ROW_W];
            in_rz_reg     <= s_axis_tdata[CTR_W + 2 * ROW_W +: ROW_W];
            in_hx_reg     <= s_axis_tdata[CTR_W + 3 * ROW_W +: HE_W];
            in_hy_reg     <= s_axis_tdata[CTR_W + 3 * ROW_W + HE_W +: HE_W];
            in_hz_reg     <= s_axis_tdata[CTR_W + 3 * ROW_W + 2 * HE_W +: HE_W];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_collides_reg <= m_collides_next;
        m_axis_reg     <= m_axis_next;
        m_depth_reg    <= m_depth_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_depth_reg, m_axis_reg, m_collides_reg};

endmodule

/* src/boxov_chk.sv */
// port-level checker for the box overlap block, bound to the top level
module boxov_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tready,
    input  logic [boxov_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    localparam int AXIS_W  = boxov_pkg::AXIS_W;
    localparam int DEPTH_W = boxov_pkg::DEPTH_W;

    logic                 r_collides;
    logic [AXIS_W-1:0]    r_axis;
    logic [DEPTH_W-1:0]   r_depth;

    assign r_collides = m_axis_tdata[0];
    assign r_axis     = m_axis_tdata[AXIS_W:1];
    assign r_depth    = m_axis_tdata[AXIS_W + DEPTH_W:AXIS_W + 1];

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // separate boxes report zero axis and depth
    a_apart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !r_collides |-> r_axis == boxov_pkg::AXIS_X && r_depth == '0)
        else $error("separate result carries axis or depth");

    // a collision has a real axis and a positive depth
    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && r_collides |-> r_axis != boxov_pkg::AXIS_INVALID && r_depth != '0)
        else $error("collision result with bad axis or zero depth");

    // an empty result register never holds off the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind box_axis_overlap_mtv boxov_chk u_boxov_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
